>>> rtl/mpcf_pkg.sv
// Package for the media player command framer.
// Holds command codes, frame and config constants, tx word type, byte count function.
// No dependencies.
package mpcf_pkg;

  // Player command codes.
  localparam logic [7:0] CmdTrack  = 8'h03;
  localparam logic [7:0] CmdVolume = 8'h06;
  localparam logic [7:0] CmdReset  = 8'h0C;
  localparam logic [7:0] CmdPlay   = 8'h0D;
  localparam logic [7:0] CmdStop   = 8'h16;

  // Long frame constants.
  localparam logic [7:0] LongStart   = 8'h7E;
  localparam logic [7:0] LongVersion = 8'hFF;
  localparam logic [7:0] LongLength  = 8'h06;
  localparam logic [7:0] LongNoAck   = 8'h00;
  localparam logic [7:0] LongEnd     = 8'hEF;

  // Short frame constants.
  localparam logic [7:0] ShortStart    = 8'hAA;
  localparam logic [7:0] ShortTrackOp  = 8'h07;
  localparam logic [7:0] ShortTrackLen = 8'h02;
  localparam logic [7:0] ShortPlayOp   = 8'h02;
  localparam logic [7:0] ShortPlaySum  = 8'hAC;
  localparam logic [7:0] ShortStopOp   = 8'h10;
  localparam logic [7:0] ShortStopSum  = 8'hBA;
  localparam logic [7:0] ShortVolOp    = 8'h13;
  localparam logic [7:0] ShortVolLen   = 8'h01;
  localparam logic [7:0] ShortZero     = 8'h00;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegPlayerMode  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegResetVolume = 4'd1;
  localparam logic [4:0]         ResetVolumeDefault = 5'd10;

  // Modes.
  localparam logic ModeLong  = 1'b0;
  localparam logic ModeShort = 1'b1;

  // Frame byte counts.
  localparam logic [4:0] LongFrameBytes = 5'd10;
  localparam logic [4:0] LongPairBytes  = 5'd20;
  localparam logic [4:0] TrackBytes     = 5'd10;
  localparam logic [4:0] FixedBytes     = 5'd4;
  localparam logic [4:0] VolBytes       = 5'd5;
  localparam logic [4:0] NoBytes        = 5'd0;

  // One transmitted word.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last_byte;
  } tx_word_t;

  // Number of bytes one command produces in the given mode.
  function automatic logic [4:0] byte_count(logic mode, logic [7:0] cmd);
    logic [4:0] n;
    n = NoBytes;
    if (mode == ModeLong) begin
      n = (cmd == CmdReset) ? LongPairBytes : LongFrameBytes;
    end else begin
      case (cmd)
        CmdTrack:  n = TrackBytes;
        CmdPlay:   n = FixedBytes;
        CmdStop:   n = FixedBytes;
        CmdVolume: n = VolBytes;
        default:   n = NoBytes;
      endcase
    end
    return n;
  endfunction

endpackage

>>> rtl/mpcf_if.sv
// Handshake interfaces for the media player command framer.
// Request, transmit byte and configuration write channels; uses mpcf_pkg.
interface mpcf_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  req_type;
  logic [15:0] cmd_value;
  modport source (output valid, output req_type, output cmd_value, input ready);
  modport sink   (input valid, input req_type, input cmd_value, output ready);
endinterface

interface mpcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;
  logic       last_byte;
  modport source (output valid, output tx_byte, output frame_end, output last_byte,
                  input ready);
  modport sink   (input valid, input tx_byte, input frame_end, input last_byte,
                  output ready);
endinterface

interface mpcf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mpcf_pkg::CfgIdxW-1:0]  index;
  logic [mpcf_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/mpcf_byte_gen.sv
// Byte generator: forms one frame byte from the held command, its position and the config.
// Purely combinational; uses mpcf_pkg.
module mpcf_byte_gen (
  input  logic               mode_i,
  input  logic [4:0]         volume_i,
  input  logic [7:0]         cmd_i,
  input  logic [15:0]        value_i,
  input  logic [4:0]         index_i,
  input  logic [4:0]         count_i,
  output mpcf_pkg::tx_word_t word_o
);

  logic        second_frame;
  logic [4:0]  pos;
  logic [7:0]  fcmd;
  logic [15:0] fval;
  logic [15:0] sum16;
  logic [15:0] chk;
  logic [7:0]  track_sum;
  logic [7:0]  vol_sum;

  // Long frame: the second frame after a reset carries the configured reset volume.
  assign second_frame = (index_i >= mpcf_pkg::LongFrameBytes);
  assign pos   = second_frame ? (index_i - mpcf_pkg::LongFrameBytes) : index_i;
  assign fcmd  = second_frame ? mpcf_pkg::CmdVolume : cmd_i;
  assign fval  = second_frame ? {11'd0, volume_i} : value_i;
  assign sum16 = {8'd0, mpcf_pkg::LongVersion} + {8'd0, mpcf_pkg::LongLength}
               + {8'd0, fcmd} + {8'd0, fval[15:8]} + {8'd0, fval[7:0]};
  assign chk   = 16'd0 - sum16;

  // Short frame sums, low byte only.
  assign track_sum = mpcf_pkg::ShortStart + mpcf_pkg::ShortTrackOp
                   + mpcf_pkg::ShortTrackLen + value_i[15:8] + value_i[7:0];
  assign vol_sum   = mpcf_pkg::ShortStart + mpcf_pkg::ShortVolOp
                   + mpcf_pkg::ShortVolLen + value_i[7:0];

  // Select the byte at this position.
  always_comb begin
    word_o.tx_byte   = mpcf_pkg::ShortZero;
    word_o.frame_end = 1'b0;
    word_o.last_byte = (index_i == count_i - 5'd1);
    if (mode_i == mpcf_pkg::ModeLong) begin
      case (pos)
        5'd0: word_o.tx_byte = mpcf_pkg::LongStart;
        5'd1: word_o.tx_byte = mpcf_pkg::LongVersion;
        5'd2: word_o.tx_byte = mpcf_pkg::LongLength;
        5'd3: word_o.tx_byte = fcmd;
        5'd4: word_o.tx_byte = mpcf_pkg::LongNoAck;
        5'd5: word_o.tx_byte = fval[15:8];
        5'd6: word_o.tx_byte = fval[7:0];
        5'd7: word_o.tx_byte = chk[15:8];
        5'd8: word_o.tx_byte = chk[7:0];
        5'd9: begin
          word_o.tx_byte   = mpcf_pkg::LongEnd;
          word_o.frame_end = 1'b1;
        end
        default: word_o.tx_byte = mpcf_pkg::LongEnd;
      endcase
    end else begin
      case (cmd_i)
        mpcf_pkg::CmdTrack: begin
          case (index_i)
            5'd0: word_o.tx_byte = mpcf_pkg::ShortStart;
            5'd1: word_o.tx_byte = mpcf_pkg::ShortTrackOp;
            5'd2: word_o.tx_byte = mpcf_pkg::ShortTrackLen;
            5'd3: word_o.tx_byte = value_i[15:8];
            5'd4: word_o.tx_byte = value_i[7:0];
            5'd5: begin
              word_o.tx_byte   = track_sum;
              word_o.frame_end = 1'b1;
            end
            5'd6: word_o.tx_byte = mpcf_pkg::ShortStart;
            5'd7: word_o.tx_byte = mpcf_pkg::ShortPlayOp;
            5'd8: word_o.tx_byte = mpcf_pkg::ShortZero;
            5'd9: begin
              word_o.tx_byte   = mpcf_pkg::ShortPlaySum;
              word_o.frame_end = 1'b1;
            end
            default: word_o.tx_byte = mpcf_pkg::ShortZero;
          endcase
        end
        mpcf_pkg::CmdPlay, mpcf_pkg::CmdStop: begin
          case (index_i)
            5'd0: word_o.tx_byte = mpcf_pkg::ShortStart;
            5'd1: word_o.tx_byte = (cmd_i == mpcf_pkg::CmdPlay) ?
                                   mpcf_pkg::ShortPlayOp : mpcf_pkg::ShortStopOp;
            5'd2: word_o.tx_byte = mpcf_pkg::ShortZero;
            5'd3: begin
              word_o.tx_byte   = (cmd_i == mpcf_pkg::CmdPlay) ?
                                 mpcf_pkg::ShortPlaySum : mpcf_pkg::ShortStopSum;
              word_o.frame_end = 1'b1;
            end
            default: word_o.tx_byte = mpcf_pkg::ShortZero;
          endcase
        end
        mpcf_pkg::CmdVolume: begin
          case (index_i)
            5'd0: word_o.tx_byte = mpcf_pkg::ShortStart;
            5'd1: word_o.tx_byte = mpcf_pkg::ShortVolOp;
            5'd2: word_o.tx_byte = mpcf_pkg::ShortVolLen;
            5'd3: word_o.tx_byte = value_i[7:0];
            5'd4: begin
              word_o.tx_byte   = vol_sum;
              word_o.frame_end = 1'b1;
            end
            default: word_o.tx_byte = mpcf_pkg::ShortZero;
          endcase
        end
        default: word_o.tx_byte = mpcf_pkg::ShortZero;
      endcase
    end
  end

endmodule

>>> rtl/mpcf_out_reg.sv
// Output register for the transmit byte channel.
// Holds one word until the receiver takes it; uses mpcf_pkg and mpcf_byte_if.
module mpcf_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mpcf_pkg::tx_word_t word_i,
  output logic               free_o,
  mpcf_byte_if.source        tx_o
);

  logic               valid_q;
  logic               valid_d;
  mpcf_pkg::tx_word_t word_q;

  // The register can take a word when empty or when its word leaves this cycle.
  assign free_o  = !valid_q || tx_o.ready;
  assign valid_d = load_i ? 1'b1 : (tx_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign tx_o.valid     = valid_q;
  assign tx_o.tx_byte   = word_q.tx_byte;
  assign tx_o.frame_end = word_q.frame_end;
  assign tx_o.last_byte = word_q.last_byte;

endmodule

>>> rtl/media_player_command_framer.sv
// Top level of the media player command framer.
// Uses mpcf_pkg, the channel interfaces, mpcf_byte_gen and mpcf_out_reg.
//
// Usage:
//   req_i takes one command word (req_type, cmd_value). tx_o returns the serial
//   bytes for it, one word per byte, with frame_end on the closing byte of each
//   frame and last_byte on the final byte of the command. cfg_i writes
//   player_mode (index 0) and reset_volume (index 1); other indexes are ignored.
//   Configuration must be written only while no command is in flight; the
//   block does not enforce this. Bytes reach tx_o through the output register.
// Throughput: a command producing N bytes (4 to 20) holds the byte sequencer
//   until its last byte is loaded, one byte per cycle through the output
//   register while tx_o is not stalled; the next command is taken at the edge
//   that loads the last byte. A command that produces no bytes sends nothing.
// Reset: clears the sequencer and the output register and restores
//   player_mode 0 and reset_volume 10.
// Stall: while the receiver holds ready low the output word stays put, the
//   sequencer waits, and req_i.ready stays low while bytes remain to send.
module media_player_command_framer (
  input  logic         clk_i,
  input  logic         rst_ni,
  mpcf_req_if.sink     req_i,
  mpcf_byte_if.source  tx_o,
  mpcf_cfg_if.sink     cfg_i
);

  logic        mode_q;
  logic [4:0]  volume_q;
  logic        busy_q;
  logic        busy_d;
  logic [7:0]  cmd_q;
  logic [15:0] val_q;
  logic [4:0]  idx_q;
  logic [4:0]  idx_d;
  logic [4:0]  count;
  logic        out_free;
  logic        load;
  logic        done;
  logic        accept;
  mpcf_pkg::tx_word_t word;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mpcf_pkg::ModeLong;
      volume_q <= mpcf_pkg::ResetVolumeDefault;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == mpcf_pkg::RegPlayerMode) begin
        mode_q <= cfg_i.data[0];
      end else if (cfg_i.index == mpcf_pkg::RegResetVolume) begin
        volume_q <= cfg_i.data[4:0];
      end
    end
  end

  // Byte sequencer over the held command.
  assign count  = mpcf_pkg::byte_count(mode_q, cmd_q);
  assign load   = busy_q && out_free && (count != mpcf_pkg::NoBytes);
  assign done   = busy_q && ((count == mpcf_pkg::NoBytes) ||
                             (load && (idx_q == count - 5'd1)));
  assign req_i.ready = !busy_q || done;
  assign accept = req_i.valid && req_i.ready;

  assign busy_d = accept ? 1'b1 : (done ? 1'b0 : busy_q);
  assign idx_d  = accept ? 5'd0 : (load ? idx_q + 5'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 5'd0;
      cmd_q  <= 8'd0;
      val_q  <= 16'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (accept) begin
        cmd_q <= req_i.req_type;
        val_q <= req_i.cmd_value;
      end
    end
  end

  // Byte selection for the current position.
  mpcf_byte_gen u_gen (
    .mode_i   (mode_q),
    .volume_i (volume_q),
    .cmd_i    (cmd_q),
    .value_i  (val_q),
    .index_i  (idx_q),
    .count_i  (count),
    .word_o   (word)
  );

  // Output register toward the serial transmitter.
  mpcf_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .word_i (word),
    .free_o (out_free),
    .tx_o   (tx_o)
  );

endmodule

>>> rtl/mpcf_chk.sv
// Port checker for the media player command framer, bound to the top level.
// Watches the transmit channel; depends on the top level's port names.
module mpcf_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tx_valid_i,
  input logic       tx_ready_i,
  input logic [7:0] tx_byte_i,
  input logic       tx_frame_end_i,
  input logic       tx_last_byte_i
);

  // No byte is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !tx_valid_i)
    else $error("byte offered during reset");

  // The final byte of a command always closes a frame.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_last_byte_i |-> tx_frame_end_i)
    else $error("last byte does not close a frame");

  // A stalled word stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i)
    else $error("byte withdrawn while stalled");

  // A stalled word keeps its value.
  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=>
      $stable(tx_byte_i) && $stable(tx_frame_end_i) && $stable(tx_last_byte_i))
    else $error("byte changed while stalled");

endmodule

bind media_player_command_framer mpcf_chk u_mpcf_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .tx_valid_i     (tx_o.valid),
  .tx_ready_i     (tx_o.ready),
  .tx_byte_i      (tx_o.tx_byte),
  .tx_frame_end_i (tx_o.frame_end),
  .tx_last_byte_i (tx_o.last_byte)
);
